// ===== src/lba_pkg.sv =====
// ---------------------------------------------------------------------------
// Linked block allocator package
// Sizes, status codes, operation codes and the item and link memory
// request types shared by the allocator modules.
// ---------------------------------------------------------------------------
`default_nettype none

package lba_pkg;

  localparam int NUM_BLOCKS = 64;
  localparam int MAX_FILES  = 16;

  localparam int BLK_W  = $clog2(NUM_BLOCKS);
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int FILE_W = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;

  localparam int OPERATION_W    = 2;
  localparam int FILE_ID_W      = 4;
  localparam int BLOCK_COUNT_W  = 7;
  localparam int ACTIVE_W       = 7;
  localparam int LEN_W          = 7;
  localparam int STATUS_W       = 3;
  localparam int BLOCK_NUMBER_W = 6;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(64);

  localparam logic [OPERATION_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OPERATION_W-1:0] OP_LIST   = 2'd1;
  localparam logic [OPERATION_W-1:0] OP_DELETE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_NO_FILE  = 3'd3,
    ST_BAD_SIZE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_ALLOC,
    S_WALK,
    S_NEXT,
    S_REPLY
  } state_t;

  typedef struct packed {
    status_t                   status;
    logic [BLOCK_NUMBER_W-1:0] block_number;
    logic                      last;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [BLK_W-1:0] waddr;
    logic [BLK_W-1:0] wdata;
    logic             re;
    logic [BLK_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== src/lba_link_ram.sv =====
// ---------------------------------------------------------------------------
// Link memory
// One entry per block holding the number of the following chain block.
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module lba_link_ram
  import lba_pkg::*;
(
  input  wire logic             clk,
  input  wire ram_req_t         req,
  output logic      [BLK_W-1:0] rdata
);

  logic [BLK_W-1:0] mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/lba_ctrl.sv =====
// ---------------------------------------------------------------------------
// Allocator sequencer
// Holds the free map, file table and active limit. One block index counter
// and compare unit scans the free map for add; a chain walk steps through
// the link memory for list and delete.
// ---------------------------------------------------------------------------
`default_nettype none

module lba_ctrl
  import lba_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [OPERATION_W-1:0]   operation,
  input  wire logic [FILE_ID_W-1:0]     file_id,
  input  wire logic [BLOCK_COUNT_W-1:0] block_count,
  input  wire logic                     cfg_wr_en,
  input  wire logic [ACTIVE_W-1:0]      cfg_wr_data,
  input  wire logic                     res_ready,
  output logic                          res_push,
  output res_t                          res,
  output ram_req_t                      ram_req,
  input  wire logic [BLK_W-1:0]         ram_rdata
);

  state_t                   state, state_next;
  status_t                  status_q, status_next;
  logic                     is_list, is_list_next;
  logic [FILE_W-1:0]        slot, slot_next;
  logic [BLOCK_COUNT_W-1:0] want, want_next;
  logic [CNT_W-1:0]         idx, idx_next;
  logic [CNT_W-1:0]         found, found_next;
  logic [BLK_W-1:0]         prev, prev_next;
  logic [BLK_W-1:0]         blk, blk_next;
  logic [LEN_W-1:0]         cnt, cnt_next;
  logic [NUM_BLOCKS-1:0]    free_map, free_map_next;
  logic [MAX_FILES-1:0]     file_valid, file_valid_next;
  logic [ACTIVE_W-1:0]      active_blocks;
  logic [BLK_W-1:0]         file_head [MAX_FILES];
  logic [LEN_W-1:0]         file_length [MAX_FILES];
  logic                     head_we;
  logic                     len_we;
  logic [ACTIVE_W-1:0]      limit;
  logic [FILE_W-1:0]        slot_in;
  logic                     slot_ok;
  logic [BLK_W-1:0]         idx_b;
  logic                     want_met;
  logic                     step;

  assign limit    = (active_blocks > ACTIVE_W'(NUM_BLOCKS)) ? ACTIVE_W'(NUM_BLOCKS)
                                                            : active_blocks;
  assign slot_in  = FILE_W'(file_id);
  assign slot_ok  = (int'(file_id) < MAX_FILES);
  assign idx_b    = idx[BLK_W-1:0];
  assign want_met = (BLOCK_COUNT_W'(found) == want);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      free_map      <= '1;
      file_valid    <= '0;
      active_blocks <= ACTIVE_RESET;
    end else begin
      state      <= state_next;
      free_map   <= free_map_next;
      file_valid <= file_valid_next;
      if (cfg_wr_en) begin
        active_blocks <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_q <= status_next;
    is_list  <= is_list_next;
    slot     <= slot_next;
    want     <= want_next;
    idx      <= idx_next;
    found    <= found_next;
    prev     <= prev_next;
    blk      <= blk_next;
    cnt      <= cnt_next;
    if (head_we) begin
      file_head[slot] <= idx_b;
    end
    if (len_we) begin
      file_length[slot] <= LEN_W'(found);
    end
  end

  always_comb begin
    state_next      = state;
    status_next     = status_q;
    is_list_next    = is_list;
    slot_next       = slot;
    want_next       = want;
    idx_next        = idx;
    found_next      = found;
    prev_next       = prev;
    blk_next        = blk;
    cnt_next        = cnt;
    free_map_next   = free_map;
    file_valid_next = file_valid;
    head_we         = 1'b0;
    len_we          = 1'b0;
    ram_req         = '0;
    res_push        = 1'b0;
    res             = '{status: ST_OK, block_number: '0, last: 1'b1};
    in_stall        = (state != S_IDLE);
    step            = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid && (operation == OP_ADD || operation == OP_LIST ||
                         operation == OP_DELETE)) begin
          slot_next    = slot_in;
          want_next    = block_count;
          is_list_next = (operation == OP_LIST);
          if (!slot_ok) begin
            status_next = ST_NO_FILE;
            state_next  = S_REPLY;
          end else if (operation == OP_ADD) begin
            if (file_valid[slot_in]) begin
              status_next = ST_EXISTS;
              state_next  = S_REPLY;
            end else if (block_count == '0) begin
              status_next = ST_BAD_SIZE;
              state_next  = S_REPLY;
            end else begin
              idx_next   = '0;
              found_next = '0;
              state_next = S_COUNT;
            end
          end else if (!file_valid[slot_in]) begin
            status_next = ST_NO_FILE;
            state_next  = S_REPLY;
          end else begin
            blk_next   = file_head[slot_in];
            cnt_next   = file_length[slot_in];
            state_next = S_WALK;
          end
        end
      end

      S_COUNT: begin
        if (want_met) begin
          idx_next   = '0;
          found_next = '0;
          state_next = S_ALLOC;
        end else if (ACTIVE_W'(idx) == limit) begin
          status_next = ST_NO_SPACE;
          state_next  = S_REPLY;
        end else begin
          if (free_map[idx_b]) begin
            found_next = found + 1'b1;
          end
          idx_next = idx + 1'b1;
        end
      end

      S_ALLOC: begin
        if (want_met) begin
          file_valid_next[slot] = 1'b1;
          len_we                = 1'b1;
          status_next           = ST_OK;
          state_next            = S_REPLY;
        end else begin
          if (free_map[idx_b]) begin
            free_map_next[idx_b] = 1'b0;
            if (found == '0) begin
              head_we = 1'b1;
            end else begin
              ram_req.we    = 1'b1;
              ram_req.waddr = prev;
              ram_req.wdata = idx_b;
            end
            prev_next  = idx_b;
            found_next = found + 1'b1;
          end
          idx_next = idx + 1'b1;
        end
      end

      S_WALK: begin
        step = is_list ? res_ready : 1'b1;
        if (is_list) begin
          res_push = res_ready;
          res      = '{status: ST_OK, block_number: BLOCK_NUMBER_W'(blk),
                       last: (cnt == LEN_W'(1))};
        end
        if (step) begin
          if (!is_list) begin
            free_map_next[blk] = 1'b1;
          end
          if (cnt == LEN_W'(1)) begin
            if (is_list) begin
              state_next = S_IDLE;
            end else begin
              file_valid_next[slot] = 1'b0;
              status_next           = ST_OK;
              state_next            = S_REPLY;
            end
          end else begin
            cnt_next      = cnt - 1'b1;
            ram_req.re    = 1'b1;
            ram_req.raddr = blk;
            state_next    = S_NEXT;
          end
        end
      end

      S_NEXT: begin
        blk_next   = ram_rdata;
        state_next = S_WALK;
      end

      S_REPLY: begin
        res_push = res_ready;
        res      = '{status: status_q, block_number: '0, last: 1'b1};
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/linked_block_allocator.sv =====
// ---------------------------------------------------------------------------
// Linked block allocator
// Add, list and delete files whose blocks are chained through a link
// memory and claimed from a free-block bitmap.
// ---------------------------------------------------------------------------
// Add: a count pass, then a claim pass over the free map.
// List: one item per chain block; delete frees each chain block, one reply.
// Each link step costs a registered read of the link memory.
// One item at a time; the output register holds a finished item meanwhile.
// Reset frees all blocks, empties the file table and sets the limit to 64.
// The link memory is not cleared.
`default_nettype none

module linked_block_allocator
  import lba_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [OPERATION_W-1:0]    operation,
  input  wire logic [FILE_ID_W-1:0]      file_id,
  input  wire logic [BLOCK_COUNT_W-1:0]  block_count,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic      [STATUS_W-1:0]       status,
  output logic      [BLOCK_NUMBER_W-1:0] block_number,
  output logic                           last,
  input  wire logic                      cfg_wr_en,
  input  wire logic [ACTIVE_W-1:0]       cfg_wr_data
);

  ram_req_t         ram_req;
  logic [BLK_W-1:0] ram_rdata;
  logic             res_ready;
  logic             res_push;
  res_t             res;
  res_t             res_q;

  lba_link_ram u_link_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  lba_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .file_id     (file_id),
    .block_count (block_count),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_ready   (res_ready),
    .res_push    (res_push),
    .res         (res),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q <= res;
    end
  end

  assign status       = res_q.status;
  assign block_number = res_q.block_number;
  assign last         = res_q.last;

endmodule

`default_nettype wire

// ===== src/lba_checker.sv =====
// ---------------------------------------------------------------------------
// Allocator port checker
// Watches the top level ports: held items, list items, error items and busy stall.
// ---------------------------------------------------------------------------
`default_nettype none

module lba_checker
  import lba_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [STATUS_W-1:0]       status,
  input wire logic [BLOCK_NUMBER_W-1:0] block_number,
  input wire logic                      last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({status, block_number, last}))
    else $error("stalled output item changed");

  a_mid_list_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> status == ST_OK)
    else $error("non-final item without ok status");

  a_mid_list_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input taken while a list is still in progress");

  a_error_no_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> block_number == '0 && last)
    else $error("error item with block number or not final");

endmodule

bind linked_block_allocator lba_checker u_lba_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .block_number (block_number),
  .last         (last)
);

`default_nettype wire

// ===== bench/tb_linked_block_allocator.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Linked block allocator testbench
// Feeds add, list and delete requests through a queue to a clocked driver,
// predicts every reply with a local copy of the free map, link table and
// file table, and checks each reply field by field in a clocked monitor.
// The block limit is reprogrammed between phases, with random idling on both
// sides in all but two phases.
// ---------------------------------------------------------------------------

module tb_linked_block_allocator;
  import lba_pkg::*;

  localparam logic [OPERATION_W-1:0] OP_SPARE = 2'd3;
  localparam int DRAIN_CYCLES   = 2 * NUM_BLOCKS + 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 20;

  typedef struct {
    logic [OPERATION_W-1:0]   op;
    logic [FILE_ID_W-1:0]     fid;
    logic [BLOCK_COUNT_W-1:0] cnt;
  } cmd_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [OPERATION_W-1:0]    operation = '0;
  logic [FILE_ID_W-1:0]      file_id = '0;
  logic [BLOCK_COUNT_W-1:0]  block_count = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic [BLOCK_NUMBER_W-1:0] block_number;
  logic                      last;
  logic                      cfg_wr_en = 1'b0;
  logic [ACTIVE_W-1:0]       cfg_wr_data = '0;

  cmd_t cmd_q [$];
  res_t reply_q [$];
  cmd_t cur_cmd;

  bit                  blk_free  [NUM_BLOCKS];
  logic [BLK_W-1:0]    blk_link  [NUM_BLOCKS];
  bit                  file_used [MAX_FILES];
  logic [BLK_W-1:0]    file_head [MAX_FILES];
  logic [LEN_W-1:0]    file_len  [MAX_FILES];
  logic [ACTIVE_W-1:0] limit_now;

  int idle_pct = 0;
  int gap_left = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;

  linked_block_allocator DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .file_id      (file_id),
    .block_count  (block_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .block_number (block_number),
    .last         (last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void compute_replies(cmd_t c);
    int   lim;
    int   avail;
    int   got;
    int   prev;
    int   b;
    res_t r;
    if (c.op == OP_SPARE) return;
    r.status       = ST_OK;
    r.block_number = '0;
    r.last         = 1'b1;
    if (c.op == OP_ADD) begin
      lim = (int'(limit_now) > NUM_BLOCKS) ? NUM_BLOCKS : int'(limit_now);
      if (file_used[c.fid]) begin
        r.status = ST_EXISTS;
      end else if (c.cnt == 0) begin
        r.status = ST_BAD_SIZE;
      end else begin
        avail = 0;
        for (int i = 0; i < lim; i++) if (blk_free[i]) avail++;
        if (avail < int'(c.cnt)) begin
          r.status = ST_NO_SPACE;
        end else begin
          got  = 0;
          prev = 0;
          for (int i = 0; i < lim && got < int'(c.cnt); i++) begin
            if (blk_free[i]) begin
              blk_free[i] = 1'b0;
              if (got == 0) file_head[c.fid] = BLK_W'(i);
              else blk_link[prev] = BLK_W'(i);
              prev = i;
              got++;
            end
          end
          file_len[c.fid]  = LEN_W'(got);
          file_used[c.fid] = 1'b1;
        end
      end
      reply_q.push_back(r);
    end else if (!file_used[c.fid]) begin
      r.status = ST_NO_FILE;
      reply_q.push_back(r);
    end else begin
      b = int'(file_head[c.fid]);
      for (int n = 0; n < int'(file_len[c.fid]); n++) begin
        if (c.op == OP_LIST) begin
          r.block_number = BLOCK_NUMBER_W'(b);
          r.last         = (n == int'(file_len[c.fid]) - 1);
          reply_q.push_back(r);
        end else begin
          blk_free[b] = 1'b1;
        end
        b = int'(blk_link[b]);
      end
      if (c.op == OP_DELETE) begin
        file_used[c.fid] = 1'b0;
        reply_q.push_back(r);
      end
    end
  endfunction

  function automatic void queue_cmd(logic [OPERATION_W-1:0] op, int fid, int cnt);
    cmd_t c;
    c.op  = op;
    c.fid = FILE_ID_W'(fid);
    c.cnt = BLOCK_COUNT_W'(cnt);
    cmd_q.push_back(c);
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) c.op = OP_ADD;
    else if (pick < 75) c.op = OP_LIST;
    else if (pick < 95) c.op = OP_DELETE;
    else c.op = OP_SPARE;
    c.fid = ($urandom_range(0, 3) == 0) ? FILE_ID_W'($urandom_range(0, 15))
                                        : FILE_ID_W'($urandom_range(0, 5));
    pick = $urandom_range(0, 99);
    if (pick < 5) c.cnt = '0;
    else if (pick < 75) c.cnt = BLOCK_COUNT_W'($urandom_range(1, 8));
    else if (pick < 95) c.cnt = BLOCK_COUNT_W'($urandom_range(9, 64));
    else c.cnt = BLOCK_COUNT_W'($urandom_range(65, 127));
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic settle();
    do @(negedge clk); while (cmd_q.size() != 0 || in_valid || reply_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_limit(input logic [ACTIVE_W-1:0] v);
    settle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    limit_now = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin : feed_p
    logic taken;
    taken = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (taken) compute_replies(cur_cmd);
      if (taken || !in_valid) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
          gap_left <= $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cur_cmd = cmd_q.pop_front();
          operation   <= cur_cmd.op;
          file_id     <= cur_cmd.fid;
          block_count <= cur_cmd.cnt;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_p
    res_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          report_mismatch("item with nothing expected, status", int'(status), -1);
        end else begin
          want = reply_q.pop_front();
          if (status !== want.status)
            report_mismatch("status", int'(status), int'(want.status));
          if (block_number !== want.block_number)
            report_mismatch("block_number", int'(block_number), int'(want.block_number));
          if (last !== want.last) report_mismatch("last", int'(last), int'(want.last));
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        hold_left <= $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int plan [6];
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      blk_free[i] = 1'b1;
      blk_link[i] = '0;
    end
    for (int i = 0; i < MAX_FILES; i++) begin
      file_used[i] = 1'b0;
      file_head[i] = '0;
      file_len[i]  = '0;
    end
    limit_now = ACTIVE_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 15;
    program_limit(ACTIVE_W'(64));
    queue_cmd(OP_LIST, 0, 0);
    queue_cmd(OP_DELETE, 15, 0);
    queue_cmd(OP_ADD, 0, 0);
    queue_cmd(OP_ADD, 0, 1);
    queue_cmd(OP_ADD, 0, 0);
    queue_cmd(OP_ADD, 1, 64);
    queue_cmd(OP_ADD, 1, 127);
    queue_cmd(OP_ADD, 15, 63);
    queue_cmd(OP_LIST, 15, 0);
    queue_cmd(OP_LIST, 0, 0);
    queue_cmd(OP_SPARE, 5, 99);
    queue_cmd(OP_DELETE, 0, 0);
    queue_cmd(OP_ADD, 2, 2);
    queue_cmd(OP_ADD, 2, 1);
    queue_cmd(OP_DELETE, 15, 0);
    queue_cmd(OP_LIST, 15, 0);
    queue_cmd(OP_ADD, 3, 10);
    queue_cmd(OP_DELETE, 2, 0);
    queue_cmd(OP_ADD, 4, 3);
    queue_cmd(OP_LIST, 4, 0);
    queue_cmd(OP_DELETE, 3, 0);
    queue_cmd(OP_DELETE, 4, 0);
    queue_cmd(OP_ADD, 9, 30);

    plan = '{8, 1, 0, 127, 33, $urandom_range(1, 64)};
    for (int p = 0; p < 6; p++) begin
      idle_pct = (p == 2) ? 0 : $urandom_range(5, 35);
      program_limit(ACTIVE_W'(plan[p]));
      if (p == 0) begin
        // hold a chain above the lowered limit, then walk and drop it
        queue_cmd(OP_LIST, 9, 0);
        queue_cmd(OP_DELETE, 9, 0);
      end
      repeat (PHASE_ITEMS) cmd_q.push_back(random_cmd());
    end

    idle_pct = 0;
    program_limit(ACTIVE_W'(64));
    repeat (PHASE_ITEMS) cmd_q.push_back(random_cmd());
    settle();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== linked_block_allocator.f =====
src/lba_pkg.sv
src/lba_link_ram.sv
src/lba_ctrl.sv
src/linked_block_allocator.sv
src/lba_checker.sv
bench/tb_linked_block_allocator.sv
